FILE: design/sfce_pkg.sv
`default_nettype none
package sfce_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int MODE_W  = 2;
  localparam int TOTAL_W = 24;
  localparam int GAIN_W  = 31;
  localparam int RATIO_W = 32;
  localparam int STEP_W  = 31;

  localparam int GAIN_FRAC  = 30;
  localparam int RATIO_FRAC = 22;

  localparam logic [CFG_INDEX_W-1:0] REG_FADE_MODE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_FRAMES   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_GAIN     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_RATIO     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CROSSFADE_STEP = 3'd4;

  localparam logic [MODE_W-1:0] MODE_FADE_OUT = 2'd0;
  localparam int                MODE_XFADE_BIT = 1;

  localparam logic [GAIN_W-1:0]  GAIN_ONE     = 31'h4000_0000;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET  = 24'd48000;
  localparam logic [RATIO_W-1:0] RATIO_RESET  = 32'd4193700;
  localparam logic [STEP_W-1:0]  STEP_RESET   = 31'd22369;

endpackage
`default_nettype wire

FILE: design/sfce_cfg_if.sv
`default_nettype none
interface sfce_cfg_if;
  import sfce_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/sfce_frame_if.sv
`default_nettype none
interface sfce_frame_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] from_left;
  logic signed [SAMPLE_BITS-1:0] from_right;
  logic signed [SAMPLE_BITS-1:0] to_left;
  logic signed [SAMPLE_BITS-1:0] to_right;
  logic                          restart;

  modport source (
    output valid, output from_left, output from_right, output to_left, output to_right,
    output restart, input ready
  );
  modport sink (
    input valid, input from_left, input from_right, input to_left, input to_right,
    input restart, output ready
  );
endinterface
`default_nettype wire

FILE: design/sfce_result_if.sv
`default_nettype none
interface sfce_result_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          fade_done;

  modport source (output valid, output out_left, output out_right, output fade_done,
                  input ready);
  modport sink (input valid, input out_left, input out_right, input fade_done,
                output ready);
endinterface
`default_nettype wire

FILE: design/stereo_fade_crossfade_engine.sv
`default_nettype none
// channel  | dir | payload                                           | handshake
// cfg      | in  | index, data                                       | valid/ready
// frames   | in  | from_left, from_right, to_left, to_right, restart | valid/ready
// results  | out | out_left, out_right, fade_done                    | valid/ready
//
// One frame is taken per cycle unless a stall fills all stages; results go through a, b, c.
// Gain and position update in the accepting cycle (one 31x32 multiply in that loop).
// rst clears the pipeline, reloads the registers and sets gain to 1.0, position to 0.
// A stalled result holds its stage; earlier stages keep filling until all are full.
module stereo_fade_crossfade_engine #(
  parameter int SAMPLE_BITS   = 24,
  parameter int POSITION_BITS = 24
) (
  input  logic          clk,
  input  logic          rst,
  sfce_cfg_if.sink      cfg,
  sfce_frame_if.sink    frames,
  sfce_result_if.source results
);
  import sfce_pkg::*;

  localparam int LIM_W  = (POSITION_BITS > TOTAL_W) ? POSITION_BITS : TOTAL_W;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SHR_W  = SUM_W - GAIN_FRAC;
  localparam int RPROD_W = GAIN_W + RATIO_W;
  localparam int RSCL_W  = RPROD_W - RATIO_FRAC;

  localparam logic [32:0]        POS_MAX_33 = (33'd1 << POSITION_BITS) - 33'd1;
  localparam logic [LIM_W-1:0]   POS_MAX    = POS_MAX_33[LIM_W-1:0];
  localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(1) << (GAIN_FRAC - 1);
  localparam logic [RPROD_W-1:0] RATIO_HALF = RPROD_W'(1) << (RATIO_FRAC - 1);

  function automatic logic [SAMPLE_BITS-1:0] round_sat(
    input logic [PROD_W-1:0] pa,
    input logic [PROD_W-1:0] pb
  );
    logic [SUM_W-1:0]       s;
    logic [SHR_W-1:0]       q;
    logic [SAMPLE_BITS-1:0] r;
    s = {pa[PROD_W-1], pa} + {pb[PROD_W-1], pb} + ROUND_HALF;
    q = s[SUM_W-1:GAIN_FRAC];
    if ((&q[SHR_W-1:SAMPLE_BITS-1]) || !(|q[SHR_W-1:SAMPLE_BITS-1])) begin
      r = q[SAMPLE_BITS-1:0];
    end else if (q[SHR_W-1]) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  logic [MODE_W-1:0]  fade_mode;
  logic [TOTAL_W-1:0] total_frames;
  logic [GAIN_W-1:0]  start_gain;
  logic [RATIO_W-1:0] gain_ratio;
  logic [STEP_W-1:0]  crossfade_step;

  logic [GAIN_W-1:0]        running_gain;
  logic [POSITION_BITS-1:0] frame_position;

  logic                          a_valid;
  logic signed [SAMPLE_BITS-1:0] a_from_left, a_from_right, a_to_left, a_to_right;
  logic [GAIN_W-1:0]             a_from_weight, a_to_weight;
  logic                          a_done;

  logic                     b_valid;
  logic signed [PROD_W-1:0] b_from_left, b_from_right, b_to_left, b_to_right;
  logic                     b_done;

  logic                          c_valid;
  logic signed [SAMPLE_BITS-1:0] c_left, c_right;
  logic                          c_done;

  logic c_en, b_en, a_en, take, xfade, advance, done_next;
  logic [GAIN_W-1:0]        start_clamped, gain_cur, gain_step, gain_next;
  logic [GAIN_W-1:0]        from_weight, to_weight, fade_gain, xfade_gain;
  logic [POSITION_BITS-1:0] pos_cur, position_next;
  logic [LIM_W-1:0]         total_w, limit;
  logic [RPROD_W-1:0]       ratio_prod, ratio_sum;
  logic [RSCL_W-1:0]        ratio_scaled;
  logic [GAIN_W:0]          xfade_sum;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_mode      <= MODE_FADE_OUT;
      total_frames   <= TOTAL_RESET;
      start_gain     <= GAIN_ONE;
      gain_ratio     <= RATIO_RESET;
      crossfade_step <= STEP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FADE_MODE:      fade_mode      <= cfg.data[MODE_W-1:0];
        REG_TOTAL_FRAMES:   total_frames   <= cfg.data[TOTAL_W-1:0];
        REG_START_GAIN:     start_gain     <= cfg.data[GAIN_W-1:0];
        REG_GAIN_RATIO:     gain_ratio     <= cfg.data[RATIO_W-1:0];
        REG_CROSSFADE_STEP: crossfade_step <= cfg.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign c_en         = !c_valid || results.ready;
  assign b_en         = !b_valid || c_en;
  assign a_en         = !a_valid || b_en;
  assign frames.ready = a_en;
  assign take         = frames.valid && a_en;

  always_comb begin
    xfade         = fade_mode[MODE_XFADE_BIT];
    start_clamped = (start_gain > GAIN_ONE) ? GAIN_ONE : start_gain;
    gain_cur      = frames.restart ? start_clamped : running_gain;
    pos_cur       = frames.restart ? '0 : frame_position;

    total_w = LIM_W'(total_frames);
    limit   = (total_w > POS_MAX) ? POS_MAX : total_w;
    advance = LIM_W'(pos_cur) < limit;
    position_next = advance ? pos_cur + 1'b1 : pos_cur;
    done_next     = LIM_W'(position_next) >= limit;

    ratio_prod   = RPROD_W'(gain_cur) * RPROD_W'(gain_ratio);
    ratio_sum    = ratio_prod + RATIO_HALF;
    ratio_scaled = ratio_sum[RPROD_W-1:RATIO_FRAC];
    fade_gain    = (ratio_scaled > RSCL_W'(GAIN_ONE)) ? GAIN_ONE : ratio_scaled[GAIN_W-1:0];

    xfade_sum  = {1'b0, gain_cur} + {1'b0, crossfade_step};
    xfade_gain = (xfade_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE : xfade_sum[GAIN_W-1:0];

    gain_step = xfade ? xfade_gain : fade_gain;
    gain_next = advance ? gain_step : gain_cur;

    from_weight = xfade ? GAIN_ONE - gain_cur : gain_cur;
    to_weight   = xfade ? gain_cur : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_gain   <= GAIN_ONE;
      frame_position <= '0;
    end else if (take) begin
      running_gain   <= gain_next;
      frame_position <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= frames.valid;
    end
    if (a_en) begin
      a_from_left   <= frames.from_left;
      a_from_right  <= frames.from_right;
      a_to_left     <= frames.to_left;
      a_to_right    <= frames.to_right;
      a_from_weight <= from_weight;
      a_to_weight   <= to_weight;
      a_done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_en) begin
      b_valid <= a_valid;
    end
    if (b_en) begin
      b_from_left  <= a_from_left * $signed({1'b0, a_from_weight});
      b_from_right <= a_from_right * $signed({1'b0, a_from_weight});
      b_to_left    <= a_to_left * $signed({1'b0, a_to_weight});
      b_to_right   <= a_to_right * $signed({1'b0, a_to_weight});
      b_done       <= a_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_en) begin
      c_valid <= b_valid;
    end
    if (c_en) begin
      c_left  <= round_sat(b_from_left, b_to_left);
      c_right <= round_sat(b_from_right, b_to_right);
      c_done  <= b_done;
    end
  end

  assign results.valid     = c_valid;
  assign results.out_left  = c_left;
  assign results.out_right = c_right;
  assign results.fade_done = c_done;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
import sfce_pkg::*;

localparam int SAMPLE_BITS = 24;
localparam int POSITION_BITS = 24;
localparam longint SAMPLE_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

typedef logic signed [SAMPLE_BITS-1:0] sample_t;

typedef struct {
  sample_t from_left;
  sample_t from_right;
  sample_t to_left;
  sample_t to_right;
  logic    restart;
} stereo_frame_t;

typedef struct {
  sample_t out_left;
  sample_t out_right;
  logic    fade_done;
} fade_result_t;

class fade_scoreboard;
  logic [MODE_W-1:0]        mode;
  logic [TOTAL_W-1:0]       total;
  logic [GAIN_W-1:0]        start_gain;
  logic [RATIO_W-1:0]       ratio;
  logic [STEP_W-1:0]        step;
  logic [GAIN_W-1:0]        gain;
  logic [POSITION_BITS-1:0] position;
  fade_result_t             due_results[$];
  int                       errors;

  function new();
    mode       = MODE_FADE_OUT;
    total      = TOTAL_RESET;
    start_gain = GAIN_ONE;
    ratio      = RATIO_RESET;
    step       = STEP_RESET;
    gain       = GAIN_ONE;
    position   = '0;
    errors     = 0;
  endfunction

  function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    case (index)
      REG_FADE_MODE: mode = data[MODE_W-1:0];
      REG_TOTAL_FRAMES: total = data[TOTAL_W-1:0];
      REG_START_GAIN: start_gain = data[GAIN_W-1:0];
      REG_GAIN_RATIO: ratio = data[RATIO_W-1:0];
      REG_CROSSFADE_STEP: step = data[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  // round half up, then clamp to the sample range
  function sample_t to_sample(longint acc);
    longint q;
    q = (acc + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    if (q > SAMPLE_HI) begin
      q = SAMPLE_HI;
    end else if (q < SAMPLE_LO) begin
      q = SAMPLE_LO;
    end
    return sample_t'(q);
  endfunction

  function void take_frame(stereo_frame_t f);
    longint       g;
    longint       gf;
    longint       left_acc;
    longint       right_acc;
    logic [63:0]  next_gain;
    fade_result_t r;
    if (f.restart) begin
      position = '0;
      gain = (start_gain > GAIN_ONE) ? GAIN_ONE : start_gain;
    end
    g  = longint'(gain);
    gf = (64'sd1 <<< GAIN_FRAC) - g;
    if (mode[MODE_XFADE_BIT]) begin
      left_acc  = f.from_left * gf + f.to_left * g;
      right_acc = f.from_right * gf + f.to_right * g;
    end else begin
      left_acc  = f.from_left * g;
      right_acc = f.from_right * g;
    end
    r.out_left  = to_sample(left_acc);
    r.out_right = to_sample(right_acc);
    if (position < total) begin
      position = position + 1'b1;
      if (mode[MODE_XFADE_BIT]) begin
        next_gain = 64'(gain) + 64'(step);
      end else begin
        next_gain = (64'(gain) * 64'(ratio) + (64'd1 << (RATIO_FRAC - 1))) >> RATIO_FRAC;
      end
      gain = (next_gain > 64'(GAIN_ONE)) ? GAIN_ONE : next_gain[GAIN_W-1:0];
    end
    r.fade_done = (position >= total);
    due_results.push_back(r);
  endfunction

  function void match_result(fade_result_t got);
    fade_result_t want;
    if (due_results.size() == 0) begin
      $error("result with no frame outstanding: out_left %0d out_right %0d",
             got.out_left, got.out_right);
      errors++;
      return;
    end
    want = due_results.pop_front();
    if (got.out_left !== want.out_left) begin
      $error("out_left: expected %0d, got %0d", want.out_left, got.out_left);
      errors++;
    end
    if (got.out_right !== want.out_right) begin
      $error("out_right: expected %0d, got %0d", want.out_right, got.out_right);
      errors++;
    end
    if (got.fade_done !== want.fade_done) begin
      $error("fade_done: expected %0d, got %0d", want.fade_done, got.fade_done);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_FRAMES    = 230;

  localparam logic [MODE_W-1:0]      MODE_FADE_IN   = 2'd1;
  localparam logic [MODE_W-1:0]      MODE_XFADE     = 2'd2;
  localparam logic [MODE_W-1:0]      MODE_XFADE_ALT = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED     = 3'd7;
  localparam logic [CFG_DATA_W-1:0]  RATIO_UNITY    = 32'd1 << RATIO_FRAC;
  localparam logic [CFG_DATA_W-1:0]  GAIN_UNITY     = 32'(GAIN_ONE);
  localparam sample_t                S_MAX          = sample_t'(SAMPLE_HI);
  localparam sample_t                S_MIN          = sample_t'(SAMPLE_LO);

  logic clk;
  logic rst;
  int   src_idle_pct = 0;
  int   sink_idle_pct = 0;
  int   stall_left = 0;
  int   cycles = 0;

  stereo_frame_t  frame_q[$];
  fade_scoreboard sb = new();

  sfce_cfg_if cfg_ch();
  sfce_frame_if #(.SAMPLE_BITS(SAMPLE_BITS)) frame_ch();
  sfce_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_ch();

  stereo_fade_crossfade_engine #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .frames(frame_ch),
    .results(result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (frame_ch.valid && frame_ch.ready) begin
      sb.take_frame(stereo_frame_t'{frame_ch.from_left, frame_ch.from_right,
                                    frame_ch.to_left, frame_ch.to_right,
                                    frame_ch.restart});
    end
    if (result_ch.valid && result_ch.ready) begin
      sb.match_result(fade_result_t'{result_ch.out_left, result_ch.out_right,
                                     result_ch.fade_done});
    end
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(index, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_frame(input sample_t fl, input sample_t fr, input sample_t tl,
                             input sample_t tr, input logic rs);
    frame_q.push_back(stereo_frame_t'{fl, fr, tl, tr, rs});
  endtask

  task automatic send_frames();
    stereo_frame_t f;
    while (frame_q.size() > 0) begin
      f = frame_q.pop_front();
      while ($urandom_range(99) < src_idle_pct) begin
        frame_ch.valid <= 1'b0;
        @(posedge clk);
      end
      frame_ch.valid      <= 1'b1;
      frame_ch.from_left  <= f.from_left;
      frame_ch.from_right <= f.from_right;
      frame_ch.to_left    <= f.to_left;
      frame_ch.to_right   <= f.to_right;
      frame_ch.restart    <= f.restart;
      @(posedge clk);
      while (!frame_ch.ready) @(posedge clk);
    end
    frame_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    do @(posedge clk); while (sb.due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(15))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic queue_random_frames(input int n);
    for (int i = 0; i < n; i++) begin
      queue_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                  (i == 0) || ($urandom_range(31) == 0));
    end
  endtask

  task automatic randomize_settings();
    logic [CFG_DATA_W-1:0] total;
    logic [CFG_DATA_W-1:0] start;
    logic [CFG_DATA_W-1:0] ratio;
    logic [CFG_DATA_W-1:0] step;
    case ($urandom_range(9))
      0: total = '0;
      1: total = 32'(24'hFF_FFFF);
      2: total = $urandom();
      default: total = $urandom_range(1, 48);
    endcase
    case ($urandom_range(7))
      0: start = '0;
      1: start = GAIN_UNITY;
      2: start = $urandom();
      3: start = GAIN_UNITY / 1000;
      default: start = $urandom_range(0, GAIN_UNITY);
    endcase
    case ($urandom_range(9))
      0: ratio = '0;
      1: ratio = '1;
      2: ratio = $urandom();
      3, 4, 5: ratio = RATIO_UNITY - $urandom_range(0, 600000);
      default: ratio = RATIO_UNITY + $urandom_range(0, 700000);
    endcase
    case ($urandom_range(7))
      0: step = '0;
      1: step = GAIN_UNITY;
      2: step = $urandom();
      default: step = $urandom_range(0, GAIN_UNITY / 8);
    endcase
    write_reg(REG_FADE_MODE, $urandom());
    write_reg(REG_TOTAL_FRAMES, total);
    write_reg(REG_START_GAIN, start);
    write_reg(REG_GAIN_RATIO, ratio);
    write_reg(REG_CROSSFADE_STEP, step);
  endtask

  initial begin
    int n;
    int count;
    rst                 <= 1'b1;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= '0;
    cfg_ch.data         <= '0;
    frame_ch.valid      <= 1'b0;
    frame_ch.from_left  <= '0;
    frame_ch.from_right <= '0;
    frame_ch.to_left    <= '0;
    frame_ch.to_right   <= '0;
    frame_ch.restart    <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, starting from unity gain
    queue_frame(S_MAX, S_MIN, S_MAX, S_MIN, 1'b0);
    queue_frame(S_MIN, S_MAX, '0, '0, 1'b0);
    queue_frame(sample_t'(1), '1, '1, sample_t'(1), 1'b1);
    send_frames();
    wait_for_results();

    // fade in from a tiny gain with the largest ratio
    write_reg(REG_FADE_MODE, 32'(MODE_FADE_IN));
    write_reg(REG_START_GAIN, 32'd1);
    write_reg(REG_GAIN_RATIO, '1);
    write_reg(REG_TOTAL_FRAMES, 32'd3);
    queue_frame(S_MAX, S_MIN, S_MIN, S_MAX, 1'b1);
    repeat (3) queue_frame(S_MAX, S_MIN, rand_sample(), rand_sample(), 1'b0);
    send_frames();
    wait_for_results();

    // zero length fade, start gain above one
    write_reg(REG_FADE_MODE, 32'(MODE_FADE_OUT));
    write_reg(REG_TOTAL_FRAMES, '0);
    write_reg(REG_START_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_GAIN_RATIO, '0);
    queue_frame(S_MAX, S_MIN, rand_sample(), rand_sample(), 1'b1);
    queue_frame(S_MIN, S_MAX, rand_sample(), rand_sample(), 1'b0);
    send_frames();
    wait_for_results();

    // linear crossfade
    write_reg(REG_FADE_MODE, 32'(MODE_XFADE));
    write_reg(REG_TOTAL_FRAMES, 32'd5);
    write_reg(REG_START_GAIN, '0);
    write_reg(REG_CROSSFADE_STEP, GAIN_UNITY / 4);
    queue_frame(S_MAX, S_MIN, S_MIN, S_MAX, 1'b1);
    repeat (5) queue_frame(S_MAX, S_MIN, S_MIN, S_MAX, 1'b0);
    send_frames();
    wait_for_results();

    // top mode value with an oversized step
    write_reg(REG_FADE_MODE, 32'(MODE_XFADE_ALT));
    write_reg(REG_TOTAL_FRAMES, 32'd2);
    write_reg(REG_CROSSFADE_STEP, '1);
    queue_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(), 1'b1);
    repeat (2) queue_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(), 1'b0);
    send_frames();
    wait_for_results();

    // register writes mid-fade leave the running gain alone
    write_reg(REG_FADE_MODE, 32'(MODE_FADE_OUT));
    write_reg(REG_TOTAL_FRAMES, 32'(24'hFF_FFFF));
    write_reg(REG_START_GAIN, GAIN_UNITY / 2);
    write_reg(REG_GAIN_RATIO, RATIO_UNITY - 1000);
    queue_frame(S_MAX, S_MIN, rand_sample(), rand_sample(), 1'b1);
    queue_frame(S_MAX, S_MIN, rand_sample(), rand_sample(), 1'b0);
    send_frames();
    wait_for_results();
    write_reg(REG_START_GAIN, '0);
    write_reg(REG_UNUSED, '1);
    repeat (2) queue_frame(S_MAX, S_MIN, rand_sample(), rand_sample(), 1'b0);
    send_frames();
    wait_for_results();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 36 : (phase == 1) ? 48 : 0;
      sink_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 36 : 0;
      count = 0;
      while (count < PHASE_FRAMES) begin
        randomize_settings();
        n = $urandom_range(8, 48);
        if (phase == 2 && count == 0) begin
          n = 48;
          stall_left = HOLD_OFF_CYCLES;
        end
        queue_random_frames(n);
        send_frames();
        wait_for_results();
        count += n;
      end
    end

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
